>>> rtl/core/mqdr_pkg.sv
`default_nettype none

package mqdr_pkg;

  // sizing of the shared store
  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int ID_WIDTH    = 16;

  localparam int QW          = $clog2(NUM_QUEUES);
  localparam int PW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int AW          = $clog2(NUM_QUEUES + 1);
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SAW         = $clog2(STORE_DEPTH);

  // stream field layout
  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 3;
  localparam int USER_ID_W   = 16;
  localparam int SERVED_ID_W = 16;
  localparam int STATUS_W    = 3;
  localparam int CFG_W       = 4;
  localparam int ACT_LSB     = 0;
  localparam int IDX_LSB     = ACT_LSB + ACTION_W;
  localparam int UID_LSB     = IDX_LSB + INDEX_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int SVALID_BIT  = SERVED_ID_W;
  localparam int STATUS_LSB  = SVALID_BIT + 1;
  localparam int TEMPTY_BIT  = STATUS_LSB + STATUS_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(NUM_QUEUES);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_CLOSE   = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_OTHER  = 3'd4
  } status_e;

  typedef struct packed {
    logic    capture;
    logic    enq;
    logic    deq_read;
    logic    drain_start;
    logic    drain_step;
    logic    drain_finish;
    logic    res_load;
    logic    res_served;
    status_e res_status;
    logic    res_tempty;
  } cmd_t;

  typedef struct packed {
    logic    out_free;
    action_e action;
    logic    bad_index;
    logic    few_queues;
    logic    q_empty;
    logic    q_full;
    logic    drain_done;
    logic    drop_seen;
  } sts_t;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mqdr_ram.sv
`default_nettype none

module mqdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/mqdr_ctrl.sv
`default_nettype none

module mqdr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mqdr_pkg::sts_t sts_i,
  output mqdr_pkg::cmd_t      cmd_o
);

  import mqdr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_DEQ   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    cmd.res_status = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd.capture = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (sts_i.bad_index) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_BAD_INDEX;
        end else begin
          case (sts_i.action)
            ACT_ENQUEUE: begin
              cmd.res_load = 1'b1;
              if (sts_i.q_full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.enq = 1'b1;
              end
            end
            ACT_DEQUEUE: begin
              if (sts_i.q_empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_EMPTY;
                cmd.res_tempty = 1'b1;
              end else begin
                cmd.deq_read = 1'b1;
                state_d      = S_DEQ;
              end
            end
            ACT_CLOSE: begin
              if (sts_i.few_queues) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_NO_OTHER;
                cmd.res_tempty = sts_i.q_empty;
              end else if (sts_i.q_empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_tempty = 1'b1;
              end else begin
                cmd.drain_start = 1'b1;
                state_d         = S_DRAIN;
              end
            end
            default: begin
              cmd.res_load   = 1'b1;
              cmd.res_tempty = sts_i.q_empty;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd.res_load   = 1'b1;
        cmd.res_served = 1'b1;
        cmd.res_tempty = sts_i.q_empty;
        state_d        = S_IDLE;
      end
      S_DRAIN: begin
        cmd.drain_step = 1'b1;
        if (sts_i.drain_done) begin
          cmd.drain_finish = 1'b1;
          cmd.res_load     = 1'b1;
          cmd.res_status   = sts_i.drop_seen ? ST_FULL : ST_OK;
          cmd.res_tempty   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

>>> rtl/core/mqdr_dp.sv
`default_nettype none

module mqdr_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mqdr_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire logic [mqdr_pkg::IN_TDATA_W-1:0]   in_data_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic      [mqdr_pkg::OUT_TDATA_W-1:0]  out_data_o,
  input  wire mqdr_pkg::cmd_t                    cmd_i,
  output mqdr_pkg::sts_t                         sts_o
);

  import mqdr_pkg::*;

  logic [CFG_W-1:0]    cfg_q;
  action_e             action_q;
  logic [INDEX_W-1:0]  index_q;
  logic [ID_WIDTH-1:0] uid_q;

  logic [PW-1:0] head_q [NUM_QUEUES];
  logic [PW-1:0] tail_q [NUM_QUEUES];
  logic [CW-1:0] cnt_q  [NUM_QUEUES];

  // drain pipeline: read source entry, then write it to its receiver
  logic [CW-1:0] rem_q;
  logic [PW-1:0] src_q;
  logic [QW-1:0] recv_q;
  logic          pend_q;
  logic [QW-1:0] pend_recv_q;
  logic          drop_q;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [AW-1:0]       act;
  logic [QW-1:0]       tq;
  logic [QW-1:0]       sel;
  logic [CW-1:0]       sel_cnt;
  logic [PW-1:0]       sel_tail;
  logic                sel_full;
  logic [QW-1:0]       first_recv;
  logic [QW:0]         nr;
  logic [QW-1:0]       next_recv;
  logic                ram_we;
  logic [SAW-1:0]      ram_waddr;
  logic [ID_WIDTH-1:0] ram_wdata;
  logic                ram_re;
  logic [SAW-1:0]      ram_raddr;
  logic [ID_WIDTH-1:0] ram_rdata;
  logic                push_ok;
  logic [SERVED_ID_W-1:0] served;

  always_comb begin
    act = (int'(cfg_q) > NUM_QUEUES) ? AW'(NUM_QUEUES) : AW'(cfg_q);
    tq  = QW'(index_q);
    sel = pend_q ? pend_recv_q : tq;
    sel_cnt  = cnt_q[sel];
    sel_tail = tail_q[sel];
    sel_full = (sel_cnt == CW'(QUEUE_DEPTH));

    first_recv = (tq == '0) ? QW'(1) : '0;
    nr = {1'b0, recv_q} + (QW+1)'(1);
    if (nr == {1'b0, tq}) begin
      nr = nr + (QW+1)'(1);
    end
    next_recv = (int'(nr) >= int'(act)) ? first_recv : nr[QW-1:0];

    push_ok   = cmd_i.drain_step && pend_q && !sel_full;
    ram_we    = cmd_i.enq || push_ok;
    ram_waddr = SAW'(sel) * SAW'(QUEUE_DEPTH) + SAW'(sel_tail);
    ram_wdata = pend_q ? ram_rdata : uid_q;
    ram_re    = cmd_i.deq_read || (cmd_i.drain_step && (rem_q != '0));
    ram_raddr = SAW'(tq) * SAW'(QUEUE_DEPTH)
              + SAW'(cmd_i.drain_step ? src_q : head_q[tq]);

    served = cmd_i.res_served ? SERVED_ID_W'(ram_rdata) : '0;
  end

  mqdr_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      uid_q <= ID_WIDTH'(in_data_i[UID_LSB +: USER_ID_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      action_q    <= ACT_ENQUEUE;
      index_q     <= '0;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      cnt_q       <= '{default: '0};
      rem_q       <= '0;
      src_q       <= '0;
      recv_q      <= '0;
      pend_q      <= 1'b0;
      pend_recv_q <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        action_q <= action_e'(in_data_i[ACT_LSB +: ACTION_W]);
        index_q  <= in_data_i[IDX_LSB +: INDEX_W];
      end
      if (cmd_i.enq) begin
        tail_q[tq] <= next_ptr(tail_q[tq]);
        cnt_q[tq]  <= cnt_q[tq] + CW'(1);
      end
      if (cmd_i.deq_read) begin
        head_q[tq] <= next_ptr(head_q[tq]);
        cnt_q[tq]  <= cnt_q[tq] - CW'(1);
      end
      if (cmd_i.drain_start) begin
        rem_q  <= sel_cnt;
        src_q  <= head_q[tq];
        recv_q <= first_recv;
        pend_q <= 1'b0;
        drop_q <= 1'b0;
      end
      if (cmd_i.drain_step) begin
        if (rem_q != '0) begin
          src_q       <= next_ptr(src_q);
          rem_q       <= rem_q - CW'(1);
          pend_q      <= 1'b1;
          pend_recv_q <= recv_q;
          recv_q      <= next_recv;
        end else begin
          pend_q <= 1'b0;
        end
        if (pend_q) begin
          if (sel_full) begin
            drop_q <= 1'b1;
          end else begin
            tail_q[sel] <= next_ptr(sel_tail);
            cnt_q[sel]  <= sel_cnt + CW'(1);
          end
        end
      end
      // src has walked the whole queue, so it now equals the tail
      if (cmd_i.drain_finish) begin
        head_q[tq] <= src_q;
        cnt_q[tq]  <= '0;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= OUT_TDATA_W'({cmd_i.res_tempty, cmd_i.res_status,
                                     cmd_i.res_served, served});
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.action     = action_q;
    sts_o.bad_index  = (int'(index_q) >= int'(act));
    sts_o.few_queues = (int'(act) < 2);
    sts_o.q_empty    = (sel_cnt == '0);
    sts_o.q_full     = sel_full;
    sts_o.drain_done = (rem_q == '0) && !pend_q;
    sts_o.drop_seen  = drop_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/multi_queue_with_drain_redistribution.sv
// channel  | dir | signals                          | content
// ---------+-----+----------------------------------+------------------------------------
// s_axis   | in  | s_axis_tvalid/tready/tdata[23:0] | action, queue_index, user_id
// m_axis   | out | m_axis_tvalid/tready/tdata[23:0] | served_id, served_valid, status,
//          |     |                                  | target_empty
// cfg      | in  | cfg_we_i, cfg_wdata_i[3:0]       | active_queues, written when we high
//
// one transaction in flight at a time: enqueue and all flagged cases load their result in the
// execute state; a dequeue adds one registered read of the shared store before its result
// a close of a queue holding n entries walks them with one store read and, unless the receiver
// is full, one store write per cycle, overlapped through the single store port pair
// rst_ni clears pointers, counts and control; active_queues resets to 8; store not cleared
// the result waits in an output register; a new transaction is taken once it is taken
// or being taken in the same cycle
`default_nettype none

module multi_queue_with_drain_redistribution (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // active_queues register
  input  wire logic                              cfg_we_i,
  input  wire logic [mqdr_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [1:0] action, [4:2] queue_index, [20:5] user_id, [23:21] zero
  input  wire logic [mqdr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [15:0] served_id, [16] served_valid, [19:17] status, [20] target_empty, [23:21] zero
  output logic      [mqdr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import mqdr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: decodes the captured transaction, sequences dequeue and drain
  mqdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: queue pointers and counts, shared store, drain pipeline, result register
  mqdr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef NO_ASSERTIONS
  // only one transaction is worked on at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a transaction is in progress");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending result");

  // a served id only comes with an ok status
  a_served_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[SVALID_BIT])
      |-> (m_axis_tdata[STATUS_LSB +: STATUS_W] == ST_OK))
    else $error("served id with an error status");
`endif

endmodule

`default_nettype wire
